>>> rtl/mpvm_pkg.sv
// ----------------------------------------------------------------------------
// mpvm_pkg
// Shared types, codes and the note frequency table of the MIDI voice mapper.
// ----------------------------------------------------------------------------
package mpvm_pkg;

  localparam int unsigned KEYS      = 128;
  localparam int unsigned KEY_W     = 7;
  localparam int unsigned MAX_WRITES = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [4:0]  NO_VOICE    = 5'd31;
  localparam logic [4:0]  NO_OWNER    = 5'd31;
  localparam logic [13:0] BEND_CENTRE = 14'd8192;
  localparam logic [6:0]  PAN_LEFT_LIMIT  = 7'd96;
  localparam logic [6:0]  PAN_RIGHT_LIMIT = 7'd32;

  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_CC       = 4'hB;
  localparam logic [3:0] KIND_BEND     = 4'hE;

  localparam logic [6:0] CC_MODULATION = 7'h01;
  localparam logic [6:0] CC_VOLUME     = 7'h07;
  localparam logic [6:0] CC_BALANCE    = 7'h08;

  localparam logic [CFG_IDX_W-1:0] CFG_PSG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_VELOCITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM     = 2'd2;

  typedef enum logic [2:0] {
    TGT_FREQ  = 3'd0,
    TGT_WAVE  = 3'd1,
    TGT_PW    = 3'd2,
    TGT_LEFT  = 3'd3,
    TGT_RIGHT = 3'd4,
    TGT_VOL   = 3'd5
  } target_e;

  typedef enum logic [2:0] {
    MSG_NONE, MSG_OFF, MSG_ON, MSG_MOD, MSG_VOL, MSG_PAN, MSG_BEND
  } msg_e;

  typedef enum logic [2:0] {
    VAL_FREQ, VAL_WAVE, VAL_MOD, VAL_LEFT, VAL_RIGHT, VAL_VOL_NOTE, VAL_VOL_PLAIN, VAL_ZERO
  } val_e;

  typedef enum logic [1:0] {
    ADDR_CLEAR, ADDR_KEY, ADDR_SCAN
  } addr_e;

  typedef enum logic {
    VSRC_RAM, VSRC_FREE
  } vsrc_e;

  typedef struct packed {
    logic    load_msg;
    logic    store_set;
    addr_e   ram_addr;
    logic    ram_we;
    logic    ram_wfree;
    logic    load_v;
    vsrc_e   v_src;
    logic    set_owner;
    logic    free_owner;
    logic    freq_start;
    logic    freq_scan_key;
    logic    sqrt_start;
    logic    emit;
    logic    emit_idx_voice;
    target_e target;
    val_e    val;
    logic    flush;
  } cmd_t;

  typedef struct packed {
    msg_e kind;
    logic ch_ok;
    logic psg;
    logic v_ok;
    logic rd_ok;
    logic free_found;
    logic owner_match;
    logic emit_ok;
    logic flush_ok;
    logic sqrt_done;
  } sts_t;

  localparam logic [15:0] FREQ_TABLE [128] = '{
    16'd21, 16'd23, 16'd24, 16'd26, 16'd27, 16'd29, 16'd31, 16'd32,
    16'd34, 16'd36, 16'd39, 16'd41, 16'd43, 16'd46, 16'd49, 16'd52,
    16'd55, 16'd58, 16'd62, 16'd65, 16'd69, 16'd73, 16'd78, 16'd82,
    16'd87, 16'd93, 16'd98, 16'd104, 16'd110, 16'd117, 16'd124, 16'd131,
    16'd139, 16'd147, 16'd156, 16'd165, 16'd175, 16'd186, 16'd197, 16'd208,
    16'd221, 16'd234, 16'd248, 16'd263, 16'd278, 16'd295, 16'd312, 16'd331,
    16'd351, 16'd372, 16'd394, 16'd417, 16'd442, 16'd468, 16'd496, 16'd526,
    16'd557, 16'd590, 16'd625, 16'd662, 16'd702, 16'd744, 16'd788, 16'd835,
    16'd884, 16'd937, 16'd993, 16'd1052, 16'd1114, 16'd1181, 16'd1251, 16'd1325,
    16'd1404, 16'd1488, 16'd1576, 16'd1670, 16'd1769, 16'd1874, 16'd1986, 16'd2104,
    16'd2229, 16'd2362, 16'd2502, 16'd2651, 16'd2809, 16'd2976, 16'd3153, 16'd3340,
    16'd3539, 16'd3749, 16'd3972, 16'd4209, 16'd4459, 16'd4724, 16'd5005, 16'd5303,
    16'd5618, 16'd5952, 16'd6306, 16'd6681, 16'd7078, 16'd7499, 16'd7945, 16'd8418,
    16'd8918, 16'd9448, 16'd10010, 16'd10606, 16'd11236, 16'd11904, 16'd12612, 16'd13362,
    16'd14157, 16'd14999, 16'd15891, 16'd16836, 16'd17837, 16'd18897, 16'd20021, 16'd21212,
    16'd22473, 16'd23809, 16'd25225, 16'd26725, 16'd28314, 16'd29998, 16'd31782, 16'd33672
  };

endpackage

>>> rtl/midi_to_psg_voice_mapper_unit.sv
// ----------------------------------------------------------------------------
// midi_to_psg_voice_mapper_unit
// Maps three-byte MIDI channel messages to sound generator register writes.
// ----------------------------------------------------------------------------
// One message is taken at a time. After reset a clearing pass writes "no
// voice" into all MIDI_CHANNELS*128 key entries (2048 by default), with
// input stalled. A note-on's volume write waits for the square root unit.
// Modulation and volume scan every voice; balance writes left and then
// right for each voice that the channel owns. Pitch bend walks the channel's
// 128 keys through the single key RAM port. A message for a disabled
// channel, unless it is a note-off, or one that is ignored, returns to idle
// after decode. Output stalls can hold any message; writes leave through a
// one-entry output register, with last_write_o on the final write of each
// message.
module midi_to_psg_voice_mapper_unit #(
  parameter int unsigned MIDI_CHANNELS = 16,
  parameter int unsigned VOICES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     status_byte_i,
  input  logic [6:0]                     data_one_i,
  input  logic [6:0]                     data_two_i,
  input  logic                           cfg_we_i,
  input  logic [mpvm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [3:0]                     write_voice_o,
  output logic [2:0]                     write_target_o,
  output logic [15:0]                    write_value_o,
  output logic                           last_write_o
);

  localparam int unsigned CHW = (MIDI_CHANNELS > 1) ? $clog2(MIDI_CHANNELS) : 1;
  localparam int unsigned IW  = CHW + mpvm_pkg::KEY_W + 1;

  mpvm_pkg::cmd_t cmd;
  mpvm_pkg::sts_t sts;
  logic [IW-1:0]  idx;

  mpvm_ctrl #(.MIDI_CHANNELS(MIDI_CHANNELS), .VOICES(VOICES)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  mpvm_dp #(.MIDI_CHANNELS(MIDI_CHANNELS), .VOICES(VOICES)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .idx_i          (idx),
    .sts_o          (sts),
    .status_byte_i  (status_byte_i),
    .data_one_i     (data_one_i),
    .data_two_i     (data_two_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .write_voice_o  (write_voice_o),
    .write_target_o (write_target_o),
    .write_value_o  (write_value_o),
    .last_write_o   (last_write_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a transaction is in progress");

  a_emit_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.emit_ok)
    else $error("write issued with output slot busy");

  a_flush_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.flush |-> sts.flush_ok)
    else $error("final write issued with output slot busy");
`endif

endmodule

>>> rtl/mpvm_ram.sv
// ----------------------------------------------------------------------------
// mpvm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module mpvm_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> rtl/mpvm_dp.sv
// ----------------------------------------------------------------------------
// mpvm_dp
// Datapath: message and config registers, channel settings, voice owners,
// key-to-voice RAM, bent frequency pipe, square root unit, write output.
// ----------------------------------------------------------------------------
module mpvm_dp #(
  parameter int unsigned MIDI_CHANNELS = 16,
  parameter int unsigned VOICES = 16,
  localparam int unsigned CHW = (MIDI_CHANNELS > 1) ? $clog2(MIDI_CHANNELS) : 1,
  localparam int unsigned AW  = CHW + mpvm_pkg::KEY_W,
  localparam int unsigned IW  = AW + 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mpvm_pkg::cmd_t                 cmd_i,
  input  logic [IW-1:0]                  idx_i,
  output mpvm_pkg::sts_t                 sts_o,
  input  logic [7:0]                     status_byte_i,
  input  logic [6:0]                     data_one_i,
  input  logic [6:0]                     data_two_i,
  input  logic                           cfg_we_i,
  input  logic [mpvm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [3:0]                     write_voice_o,
  output logic [2:0]                     write_target_o,
  output logic [15:0]                    write_value_o,
  output logic                           last_write_o
);

  localparam int unsigned VIW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned DEPTH = MIDI_CHANNELS * mpvm_pkg::KEYS;

  logic [7:0]  st_q;
  logic [6:0]  d1_q, d2_q;
  logic [15:0] psg_mask_q, use_vel_q;
  logic [31:0] wave_q;

  logic [13:0] bend_q [MIDI_CHANNELS];
  logic [6:0]  mod_q  [MIDI_CHANNELS];
  logic [6:0]  vol_q  [MIDI_CHANNELS];
  logic [6:0]  pan_q  [MIDI_CHANNELS];
  logic [4:0]  owner_q [VOICES];
  logic [4:0]  v_q;

  logic [3:0]     ch;
  logic [CHW-1:0] chi;
  logic           ch_ok;
  mpvm_pkg::msg_e kind;

  always_comb begin
    ch    = st_q[3:0];
    chi   = ch[CHW-1:0];
    ch_ok = ({1'b0, ch} < 5'(MIDI_CHANNELS));
    case (st_q[7:4])
      mpvm_pkg::KIND_NOTE_OFF: kind = mpvm_pkg::MSG_OFF;
      mpvm_pkg::KIND_NOTE_ON:  kind = (d2_q == 7'd0) ? mpvm_pkg::MSG_OFF : mpvm_pkg::MSG_ON;
      mpvm_pkg::KIND_CC: begin
        case (d1_q)
          mpvm_pkg::CC_MODULATION: kind = mpvm_pkg::MSG_MOD;
          mpvm_pkg::CC_VOLUME:     kind = mpvm_pkg::MSG_VOL;
          mpvm_pkg::CC_BALANCE:    kind = mpvm_pkg::MSG_PAN;
          default:                 kind = mpvm_pkg::MSG_NONE;
        endcase
      end
      mpvm_pkg::KIND_BEND: kind = mpvm_pkg::MSG_BEND;
      default:             kind = mpvm_pkg::MSG_NONE;
    endcase
  end

  // free voice search
  logic       free_found;
  logic [4:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = mpvm_pkg::NO_VOICE;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (owner_q[i] == mpvm_pkg::NO_OWNER) begin
        free_found = 1'b1;
        free_idx   = 5'(i);
      end
    end
  end

  // key to voice RAM
  logic [AW-1:0] ram_addr;
  logic [4:0]    ram_wdata, ram_rdata;
  always_comb begin
    case (cmd_i.ram_addr)
      mpvm_pkg::ADDR_CLEAR: ram_addr = idx_i[AW-1:0];
      mpvm_pkg::ADDR_SCAN:  ram_addr = {chi, idx_i[mpvm_pkg::KEY_W-1:0]};
      default:              ram_addr = {chi, d1_q};
    endcase
    ram_wdata = cmd_i.ram_wfree ? free_idx : mpvm_pkg::NO_VOICE;
  end

  mpvm_ram #(.WIDTH(5), .DEPTH(DEPTH)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // bent frequency, stage one
  logic [6:0]  fkey;
  logic [13:0] fbend;
  logic [15:0] fk, fm, fp, f0, diff;
  logic [12:0] amt;
  always_comb begin
    fkey  = cmd_i.freq_scan_key ? idx_i[mpvm_pkg::KEY_W-1:0] : d1_q;
    fbend = bend_q[chi];
    fk    = mpvm_pkg::FREQ_TABLE[fkey];
    fm    = mpvm_pkg::FREQ_TABLE[fkey - 7'd1];
    fp    = mpvm_pkg::FREQ_TABLE[fkey + 7'd1];
    f0    = fk;
    diff  = 16'd0;
    amt   = 13'd0;
    if (fbend < mpvm_pkg::BEND_CENTRE && fkey != 7'd0) begin
      f0   = fm;
      diff = fk - fm;
      amt  = fbend[12:0];
    end else if (fbend > mpvm_pkg::BEND_CENTRE && fkey != 7'd127) begin
      diff = fp - fk;
      amt  = fbend[12:0];
    end
  end

  logic [15:0] f0_q, diff_q, freq_q;
  logic [12:0] amt_q;
  logic [28:0] prod;
  assign prod = {13'd0, diff_q} * {16'd0, amt_q};

  // square root unit, one result bit per cycle
  logic [13:0] op_q;
  logic [6:0]  root_q, trial;
  logic [2:0]  bit_q;
  logic        busy_q;
  logic [13:0] trial_sq;
  always_comb begin
    trial    = root_q | (7'd1 << bit_q);
    trial_sq = {7'd0, trial} * {7'd0, trial};
  end

  // write value
  logic [6:0]  cvol, cmod, cpan;
  logic [15:0] value;
  logic [3:0]  voice;
  always_comb begin
    cvol = vol_q[chi];
    cmod = mod_q[chi];
    cpan = pan_q[chi];
    case (cmd_i.val)
      mpvm_pkg::VAL_FREQ:      value = freq_q;
      mpvm_pkg::VAL_WAVE:      value = {14'd0, wave_q[{ch, 1'b0} +: 2]};
      mpvm_pkg::VAL_MOD:       value = {10'd0, cmod[6:1]};
      mpvm_pkg::VAL_LEFT:      value = {15'd0, cpan < mpvm_pkg::PAN_LEFT_LIMIT};
      mpvm_pkg::VAL_RIGHT:     value = {15'd0, cpan > mpvm_pkg::PAN_RIGHT_LIMIT};
      mpvm_pkg::VAL_VOL_NOTE:  value = use_vel_q[ch] ? {10'd0, root_q[6:1]}
                                                     : {10'd0, cvol[6:1]};
      mpvm_pkg::VAL_VOL_PLAIN: value = {10'd0, cvol[6:1]};
      default:                 value = 16'd0;
    endcase
    voice = cmd_i.emit_idx_voice ? idx_i[3:0] : v_q[3:0];
  end

  // pending write and output register
  logic                 pend_valid_q;
  logic [3:0]           pend_voice_q;
  mpvm_pkg::target_e    pend_tgt_q;
  logic [15:0]          pend_val_q;
  logic [5:0]           cnt_q;
  logic                 out_valid_q, out_free, emit_take, flush_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_take  = cmd_i.emit && (cnt_q < 6'(mpvm_pkg::MAX_WRITES));
  assign flush_take = cmd_i.flush && pend_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psg_mask_q   <= '0;
      use_vel_q    <= '0;
      wave_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
      busy_q       <= 1'b0;
      for (int i = 0; i < VOICES; i++) owner_q[i] <= mpvm_pkg::NO_OWNER;
      for (int c = 0; c < MIDI_CHANNELS; c++) begin
        bend_q[c] <= mpvm_pkg::BEND_CENTRE;
        mod_q[c]  <= '0;
        vol_q[c]  <= '0;
        pan_q[c]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          mpvm_pkg::CFG_PSG_ENABLE:   psg_mask_q <= cfg_data_i[15:0];
          mpvm_pkg::CFG_USE_VELOCITY: use_vel_q  <= cfg_data_i[15:0];
          mpvm_pkg::CFG_WAVEFORM:     wave_q     <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.store_set && ch_ok) begin
        case (kind)
          mpvm_pkg::MSG_MOD:  mod_q[chi]  <= d2_q;
          mpvm_pkg::MSG_VOL:  vol_q[chi]  <= d2_q;
          mpvm_pkg::MSG_PAN:  pan_q[chi]  <= d2_q;
          mpvm_pkg::MSG_BEND: bend_q[chi] <= {d2_q, d1_q};
          default: ;
        endcase
      end
      if (cmd_i.set_owner)  owner_q[v_q[VIW-1:0]] <= {1'b0, ch};
      if (cmd_i.free_owner) owner_q[v_q[VIW-1:0]] <= mpvm_pkg::NO_OWNER;
      if (cmd_i.sqrt_start) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q == 3'd0) begin
        busy_q <= 1'b0;
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cmd_i.load_msg) cnt_q <= '0;
      if (emit_take) begin
        if (pend_valid_q) out_valid_q <= 1'b1;
        pend_valid_q <= 1'b1;
        cnt_q        <= cnt_q + 6'd1;
      end
      if (flush_take) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_msg) begin
      st_q <= status_byte_i;
      d1_q <= data_one_i;
      d2_q <= data_two_i;
    end
    if (cmd_i.load_v) v_q <= (cmd_i.v_src == mpvm_pkg::VSRC_FREE) ? free_idx : ram_rdata;
    if (cmd_i.freq_start) begin
      f0_q   <= f0;
      diff_q <= diff;
      amt_q  <= amt;
    end
    freq_q <= f0_q + prod[28:13];
    if (cmd_i.sqrt_start) begin
      op_q   <= {7'd0, cvol} * {7'd0, d2_q};
      root_q <= '0;
      bit_q  <= 3'd6;
    end else if (busy_q) begin
      if (trial_sq <= op_q) root_q <= trial;
      bit_q <= bit_q - 3'd1;
    end
    if (emit_take) begin
      if (pend_valid_q) begin
        write_voice_o  <= pend_voice_q;
        write_target_o <= pend_tgt_q;
        write_value_o  <= pend_val_q;
        last_write_o   <= 1'b0;
      end
      pend_voice_q <= voice;
      pend_tgt_q   <= cmd_i.target;
      pend_val_q   <= value;
    end
    if (flush_take) begin
      write_voice_o  <= pend_voice_q;
      write_target_o <= pend_tgt_q;
      write_value_o  <= pend_val_q;
      last_write_o   <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.kind        = kind;
    sts_o.ch_ok       = ch_ok;
    sts_o.psg         = psg_mask_q[ch];
    sts_o.v_ok        = (v_q < 5'(VOICES));
    sts_o.rd_ok       = (ram_rdata < 5'(VOICES));
    sts_o.free_found  = free_found;
    sts_o.owner_match = (owner_q[idx_i[VIW-1:0]] == {1'b0, ch});
    sts_o.emit_ok     = !pend_valid_q || out_free;
    sts_o.flush_ok    = !pend_valid_q || out_free;
    sts_o.sqrt_done   = !busy_q;
  end

endmodule

>>> rtl/mpvm_ctrl.sv
// ----------------------------------------------------------------------------
// mpvm_ctrl
// Controller: RAM clearing pass, message decode and the voice and key scans.
// ----------------------------------------------------------------------------
module mpvm_ctrl #(
  parameter int unsigned MIDI_CHANNELS = 16,
  parameter int unsigned VOICES = 16,
  localparam int unsigned CHW = (MIDI_CHANNELS > 1) ? $clog2(MIDI_CHANNELS) : 1,
  localparam int unsigned AW  = CHW + mpvm_pkg::KEY_W,
  localparam int unsigned IW  = AW + 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mpvm_pkg::sts_t sts_i,
  output mpvm_pkg::cmd_t cmd_o,
  output logic [IW-1:0]  idx_o
);

  localparam int unsigned DEPTH = MIDI_CHANNELS * mpvm_pkg::KEYS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_LOADV, S_OFF_DO, S_ON_SEL, S_ON_FREQ, S_ON_F2,
    S_ON_W, S_CC_SCAN, S_CC_RIGHT, S_BEND_RD, S_BEND_CHK, S_BEND_F2, S_BEND_W, S_FLUSH
  } state_e;

  state_e            state_q, state_d;
  logic [IW-1:0]     idx_q, idx_d;
  mpvm_pkg::target_e on_tgt;
  logic              on_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.ram_addr = mpvm_pkg::ADDR_KEY;
    cmd_o.target   = mpvm_pkg::TGT_FREQ;
    cmd_o.val      = mpvm_pkg::VAL_ZERO;
    state_d        = state_q;
    idx_d          = idx_q;
    on_tgt         = mpvm_pkg::target_e'(idx_q[2:0]);
    on_ok          = sts_i.emit_ok && (on_tgt != mpvm_pkg::TGT_VOL || sts_i.sqrt_done);
    case (state_q)
      S_CLEAR: begin
        cmd_o.ram_addr = mpvm_pkg::ADDR_CLEAR;
        cmd_o.ram_we   = 1'b1;
        if (idx_q == IW'(DEPTH - 1)) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_msg = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.store_set = 1'b1;
        idx_d           = '0;
        state_d         = S_IDLE;
        if (sts_i.ch_ok) begin
          case (sts_i.kind)
            mpvm_pkg::MSG_OFF: state_d = S_LOADV;
            mpvm_pkg::MSG_ON:  if (sts_i.psg) state_d = S_LOADV;
            mpvm_pkg::MSG_MOD, mpvm_pkg::MSG_VOL, mpvm_pkg::MSG_PAN: begin
              if (sts_i.psg) state_d = S_CC_SCAN;
            end
            mpvm_pkg::MSG_BEND: if (sts_i.psg) state_d = S_BEND_RD;
            default: ;
          endcase
        end
      end
      S_LOADV: begin
        cmd_o.load_v = 1'b1;
        cmd_o.v_src  = mpvm_pkg::VSRC_RAM;
        state_d      = (sts_i.kind == mpvm_pkg::MSG_ON) ? S_ON_SEL : S_OFF_DO;
      end
      S_OFF_DO: begin
        if (!(sts_i.v_ok && sts_i.psg && !sts_i.emit_ok)) begin
          cmd_o.emit       = sts_i.v_ok && sts_i.psg;
          cmd_o.target     = mpvm_pkg::TGT_VOL;
          cmd_o.free_owner = sts_i.v_ok;
          cmd_o.ram_we     = 1'b1;
          state_d          = S_FLUSH;
        end
      end
      S_ON_SEL: begin
        if (sts_i.v_ok) begin
          state_d = S_ON_FREQ;
        end else if (sts_i.free_found) begin
          cmd_o.load_v    = 1'b1;
          cmd_o.v_src     = mpvm_pkg::VSRC_FREE;
          cmd_o.ram_we    = 1'b1;
          cmd_o.ram_wfree = 1'b1;
          state_d         = S_ON_FREQ;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_ON_FREQ: begin
        cmd_o.set_owner  = 1'b1;
        cmd_o.freq_start = 1'b1;
        cmd_o.sqrt_start = 1'b1;
        idx_d            = '0;
        state_d          = S_ON_F2;
      end
      S_ON_F2: state_d = S_ON_W;
      S_ON_W: begin
        cmd_o.target = on_tgt;
        case (on_tgt)
          mpvm_pkg::TGT_FREQ:  cmd_o.val = mpvm_pkg::VAL_FREQ;
          mpvm_pkg::TGT_WAVE:  cmd_o.val = mpvm_pkg::VAL_WAVE;
          mpvm_pkg::TGT_PW:    cmd_o.val = mpvm_pkg::VAL_MOD;
          mpvm_pkg::TGT_LEFT:  cmd_o.val = mpvm_pkg::VAL_LEFT;
          mpvm_pkg::TGT_RIGHT: cmd_o.val = mpvm_pkg::VAL_RIGHT;
          default:             cmd_o.val = mpvm_pkg::VAL_VOL_NOTE;
        endcase
        if (on_ok) begin
          cmd_o.emit = 1'b1;
          if (on_tgt == mpvm_pkg::TGT_VOL) begin
            state_d = S_FLUSH;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end
      S_CC_SCAN: begin
        cmd_o.emit_idx_voice = 1'b1;
        case (sts_i.kind)
          mpvm_pkg::MSG_MOD: begin
            cmd_o.target = mpvm_pkg::TGT_PW;
            cmd_o.val    = mpvm_pkg::VAL_MOD;
          end
          mpvm_pkg::MSG_VOL: begin
            cmd_o.target = mpvm_pkg::TGT_VOL;
            cmd_o.val    = mpvm_pkg::VAL_VOL_PLAIN;
          end
          default: begin
            cmd_o.target = mpvm_pkg::TGT_LEFT;
            cmd_o.val    = mpvm_pkg::VAL_LEFT;
          end
        endcase
        if (idx_q == IW'(VOICES)) begin
          state_d = S_FLUSH;
        end else if (!sts_i.owner_match) begin
          idx_d = idx_q + IW'(1);
        end else if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          if (sts_i.kind == mpvm_pkg::MSG_PAN) begin
            state_d = S_CC_RIGHT;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end
      S_CC_RIGHT: begin
        cmd_o.emit_idx_voice = 1'b1;
        cmd_o.target         = mpvm_pkg::TGT_RIGHT;
        cmd_o.val            = mpvm_pkg::VAL_RIGHT;
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          idx_d      = idx_q + IW'(1);
          state_d    = S_CC_SCAN;
        end
      end
      S_BEND_RD: begin
        cmd_o.ram_addr = mpvm_pkg::ADDR_SCAN;
        state_d        = S_BEND_CHK;
      end
      S_BEND_CHK: begin
        cmd_o.ram_addr = mpvm_pkg::ADDR_SCAN;
        if (sts_i.rd_ok) begin
          cmd_o.load_v        = 1'b1;
          cmd_o.v_src         = mpvm_pkg::VSRC_RAM;
          cmd_o.freq_start    = 1'b1;
          cmd_o.freq_scan_key = 1'b1;
          state_d             = S_BEND_F2;
        end else if (idx_q == IW'(mpvm_pkg::KEYS - 1)) begin
          state_d = S_FLUSH;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = S_BEND_RD;
        end
      end
      S_BEND_F2: state_d = S_BEND_W;
      S_BEND_W: begin
        cmd_o.target = mpvm_pkg::TGT_FREQ;
        cmd_o.val    = mpvm_pkg::VAL_FREQ;
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          if (idx_q == IW'(mpvm_pkg::KEYS - 1)) begin
            state_d = S_FLUSH;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = S_BEND_RD;
          end
        end
      end
      S_FLUSH: begin
        if (sts_i.flush_ok) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign idx_o      = idx_q;

endmodule

>>> tb/sv/midi_to_psg_voice_mapper_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_to_psg_voice_mapper_unit_test
// Drives MIDI channel messages into the voice mapper and checks every sound
// generator register write against a voice allocation predictor.
// ----------------------------------------------------------------------------
module midi_to_psg_voice_mapper_unit_test;
  import mpvm_pkg::*;

  typedef struct packed {
    logic [3:0]  voice;
    logic [2:0]  target;
    logic [15:0] value;
    logic        last;
  } psg_write_t;

  class voice_scoreboard;
    logic [4:0]  key_voice [2048];
    logic [4:0]  voice_owner [16];
    logic [13:0] bend [16];
    logic [6:0]  modulation [16];
    logic [6:0]  volume [16];
    logic [6:0]  pan [16];
    logic [15:0] enable_mask;
    logic [15:0] velocity_mask;
    logic [31:0] wave_sel;
    psg_write_t  pending [$];
    psg_write_t  batch [$];
    int          errors;

    function new();
      for (int i = 0; i < 2048; i++) key_voice[i] = NO_VOICE;
      for (int i = 0; i < 16; i++) begin
        voice_owner[i] = NO_OWNER;
        bend[i] = BEND_CENTRE;
        modulation[i] = '0;
        volume[i] = '0;
        pan[i] = '0;
      end
      enable_mask = '0;
      velocity_mask = '0;
      wave_sel = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == CFG_PSG_ENABLE) enable_mask = val[15:0];
      else if (idx == CFG_USE_VELOCITY) velocity_mask = val[15:0];
      else if (idx == CFG_WAVEFORM) wave_sel = val;
    endfunction

    function void push(int v, target_e t, int val);
      psg_write_t w;
      if (batch.size() >= MAX_WRITES) return;
      w.voice = v[3:0];
      w.target = t;
      w.value = val[15:0];
      w.last = 1'b0;
      batch.push_back(w);
    endfunction

    function int bent(int key, int b);
      int f0, f1, amt;
      if (b == 8192) return FREQ_TABLE[key];
      if (b < 8192) begin
        if (key == 0) return FREQ_TABLE[key];
        f0 = FREQ_TABLE[key - 1];
        f1 = FREQ_TABLE[key];
        amt = b;
      end else begin
        if (key == 127) return FREQ_TABLE[key];
        f0 = FREQ_TABLE[key];
        f1 = FREQ_TABLE[key + 1];
        amt = b - 8192;
      end
      return (f0 + (((f1 - f0) * amt) >>> 13)) & 16'hFFFF;
    endfunction

    function int root_floor(int v);
      int r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
    endfunction

    function void release_key(int ch, int key, bit psg);
      int idx, v;
      idx = ch * 128 + key;
      v = key_voice[idx];
      if (v < 16) begin
        if (psg) push(v, TGT_VOL, 0);
        voice_owner[v] = NO_OWNER;
      end
      key_voice[idx] = NO_VOICE;
    endfunction

    function void note_accepted(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
      int ch, idx, v, vol;
      bit psg;
      ch = st[3:0];
      psg = enable_mask[ch];
      batch.delete();
      case (st[7:4])
        KIND_NOTE_OFF: release_key(ch, d1, psg);
        KIND_NOTE_ON: begin
          if (d2 == 0) release_key(ch, d1, psg);
          else if (psg) begin
            idx = ch * 128 + d1;
            v = key_voice[idx];
            if (v >= 16) begin
              v = 31;
              for (int i = 0; i < 16; i++)
                if (v == 31 && voice_owner[i] == NO_OWNER) v = i;
              if (v < 16) key_voice[idx] = 5'(v);
            end
            if (v < 16) begin
              voice_owner[v] = 5'(ch);
              push(v, TGT_FREQ, bent(d1, bend[ch]));
              push(v, TGT_WAVE, (wave_sel >> (2 * ch)) & 3);
              push(v, TGT_PW, modulation[ch] >> 1);
              push(v, TGT_LEFT, pan[ch] < PAN_LEFT_LIMIT);
              push(v, TGT_RIGHT, pan[ch] > PAN_RIGHT_LIMIT);
              if (velocity_mask[ch]) vol = root_floor(volume[ch] * d2) >> 1;
              else vol = volume[ch] >> 1;
              push(v, TGT_VOL, vol);
            end
          end
        end
        KIND_CC: begin
          if (d1 == CC_MODULATION) begin
            if (psg) for (int i = 0; i < 16; i++)
              if (voice_owner[i] == ch) push(i, TGT_PW, d2 >> 1);
            modulation[ch] = d2;
          end else if (d1 == CC_VOLUME) begin
            if (psg) for (int i = 0; i < 16; i++)
              if (voice_owner[i] == ch) push(i, TGT_VOL, d2 >> 1);
            volume[ch] = d2;
          end else if (d1 == CC_BALANCE) begin
            pan[ch] = d2;
            if (psg) for (int i = 0; i < 16; i++)
              if (voice_owner[i] == ch) begin
                push(i, TGT_LEFT, d2 < PAN_LEFT_LIMIT);
                push(i, TGT_RIGHT, d2 > PAN_RIGHT_LIMIT);
              end
          end
        end
        KIND_BEND: begin
          if (psg) for (int k = 0; k < 128; k++) begin
            v = key_voice[ch * 128 + k];
            if (v < 16) push(v, TGT_FREQ, bent(k, {d2, d1}));
          end
          bend[ch] = {d2, d1};
        end
        default: ;
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) pending.push_back(batch[i]);
    endfunction

    function void check_write(psg_write_t got);
      psg_write_t exp_w;
      if (pending.size() == 0) begin
        $error("unexpected write voice=%0d target=%0d value=%0d",
               got.voice, got.target, got.value);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.voice !== exp_w.voice) begin
        $error("write_voice expected %0d actual %0d", exp_w.voice, got.voice); errors++;
      end
      if (got.target !== exp_w.target) begin
        $error("write_target expected %0d actual %0d", exp_w.target, got.target); errors++;
      end
      if (got.value !== exp_w.value) begin
        $error("write_value expected %0d actual %0d", exp_w.value, got.value); errors++;
      end
      if (got.last !== exp_w.last) begin
        $error("last_write expected %0d actual %0d", exp_w.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [7:0]  status_byte_i = 8'h80;
  logic [6:0]  data_one_i = 0;
  logic [6:0]  data_two_i = 0;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_index_i = 0;
  logic [31:0] cfg_data_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [3:0]  write_voice_o;
  logic [2:0]  write_target_o;
  logic [15:0] write_value_o;
  logic        last_write_o;

  voice_scoreboard sb = new();
  int  cycle_count = 0;
  int  hold_off = 0;
  bit  calm = 0;

  midi_to_psg_voice_mapper_unit dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_write({write_voice_o, write_target_o, write_value_o, last_write_o});

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_stall_i <= 1'b1;
      hold_off <= hold_off - 1;
    end else out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 31);
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic send_msg(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    status_byte_i <= st;
    data_one_i <= d1;
    data_two_i <= d2;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_accepted(st, d1, d2);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    while (sb.pending.size() > 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (400) @(posedge clk_i);
  endtask

  task automatic random_msg();
    logic [7:0] st;
    logic [6:0] d1;
    logic [6:0] d2;
    int r;
    r = $urandom_range(99);
    st = {4'h0, 4'($urandom_range(15))};
    if ($urandom_range(3) != 0) st[3:0] = 4'($urandom_range(3));
    d1 = 7'($urandom_range(127));
    if ($urandom_range(1)) d1 = 7'(36 + $urandom_range(11));
    d2 = 7'($urandom_range(127));
    if (r < 40) st[7:4] = KIND_NOTE_ON;
    else if (r < 65) st[7:4] = KIND_NOTE_OFF;
    else if (r < 83) begin
      st[7:4] = KIND_CC;
      case ($urandom_range(3))
        0: d1 = CC_MODULATION;
        1: d1 = CC_VOLUME;
        2: d1 = CC_BALANCE;
        default: ;
      endcase
    end else if (r < 90) st[7:4] = KIND_BEND;
    else st = 8'($urandom_range(255));
    send_msg(st, d1, d2);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(CFG_PSG_ENABLE, 32'h0000_FFFF);
    write_reg(CFG_USE_VELOCITY, 32'h0000_AAAA);
    write_reg(CFG_WAVEFORM, 32'hFFFF_FFFF);
    send_msg({KIND_CC, 4'h0}, CC_VOLUME, 7'd127);
    send_msg({KIND_CC, 4'h1}, CC_VOLUME, 7'd100);
    send_msg({KIND_CC, 4'h0}, CC_BALANCE, 7'd127);
    send_msg({KIND_NOTE_ON, 4'h0}, 7'd0, 7'd127);
    send_msg({KIND_NOTE_ON, 4'h1}, 7'd127, 7'd1);
    send_msg({KIND_NOTE_ON, 4'h1}, 7'd127, 7'd90);
    send_msg({KIND_CC, 4'h0}, CC_MODULATION, 7'd127);
    send_msg({KIND_CC, 4'h0}, CC_BALANCE, 7'd0);
    send_msg({KIND_BEND, 4'h0}, 7'd0, 7'd0);
    send_msg({KIND_BEND, 4'h1}, 7'd127, 7'd127);
    send_msg({KIND_BEND, 4'h0}, 7'd0, 7'd64);
    send_msg({KIND_NOTE_ON, 4'h0}, 7'd0, 7'd0);
    send_msg({KIND_NOTE_OFF, 4'h1}, 7'd127, 7'd0);
    send_msg(8'hA0, 7'd5, 7'd5);
    send_msg(8'hC3, 7'd5, 7'd5);
    send_msg(8'hD0, 7'd5, 7'd5);
    send_msg(8'hF0, 7'd5, 7'd5);
    send_msg({KIND_CC, 4'h0}, 7'd64, 7'd5);
    for (int k = 0; k < 17; k++) send_msg({KIND_NOTE_ON, 4'h2}, k[6:0], 7'd64);
    send_msg({KIND_BEND, 4'h2}, 7'd55, 7'd20);
    settle();

    write_reg(CFG_PSG_ENABLE, 32'h0000_0005);
    write_reg(CFG_USE_VELOCITY, 32'h0000_0000);
    send_msg({KIND_NOTE_OFF, 4'h1}, 7'd1, 7'd0);
    send_msg({KIND_NOTE_ON, 4'h1}, 7'd1, 7'd9);
    for (int k = 0; k < 17; k++) send_msg({KIND_NOTE_OFF, 4'h2}, k[6:0], 7'd0);
    settle();

    fork
      hold_off = 600;
      for (int i = 0; i < 20; i++) random_msg();
    join
    settle();

    for (int ph = 0; ph < 3; ph++) begin
      write_reg(CFG_PSG_ENABLE, ph == 2 ? 32'h0000_FFFF : $urandom_range(65535));
      write_reg(CFG_USE_VELOCITY, ph == 1 ? 32'h0 : $urandom_range(65535));
      write_reg(CFG_WAVEFORM, {16'($urandom_range(65535)), 16'($urandom_range(65535))});
      calm = (ph == 1);
      for (int i = 0; i < 132; i++) random_msg();
      calm = 0;
      settle();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("Verification passed");
    else begin
      if (sb.pending.size() > 0)
        $error("%0d expected writes never arrived", sb.pending.size());
      $display("Verification failed");
    end
    $finish;
  end
endmodule
